// ----- hw/rtl/pjn_pkg.sv -----
// Package for the path join normaliser: command and phase codes, queue item type,
// payload widths and default sizes. No dependencies.
package pjn_pkg;

  localparam int CMD_W            = 2;
  localparam int CHAR_W           = 8;
  localparam int PATH_CHARS_DEF   = 128;
  localparam int MAX_SEGMENTS_DEF = 128;
  localparam int Q_DEPTH          = 2;

  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_BASE   = 2'd1,
    CMD_SECOND = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_BASE   = 2'd1,
    PH_SECOND = 2'd2,
    PH_READ   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    B_IDLE  = 3'd0,
    B_POP   = 3'd1,
    B_RD    = 3'd2,
    B_SLASH = 3'd3,
    B_CHAR  = 3'd4
  } bst_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [CHAR_W-1:0] ch;
    logic              is_slash;
    logic              is_dot;
    logic              is_nul;
  } item_t;

endpackage

// ----- hw/rtl/pjn_if.sv -----
// Valid/ready channel interfaces for the path join normaliser.
// Depends on pjn_pkg for payload widths.
interface pjn_in_if;
  logic                         valid;
  logic                         ready;
  logic [pjn_pkg::CMD_W-1:0]    command;
  logic [pjn_pkg::CHAR_W-1:0]   char_in;
  modport source (output valid, command, char_in, input ready);
  modport sink   (input valid, command, char_in, output ready);
endinterface

interface pjn_out_if;
  logic                         valid;
  logic                         ready;
  logic [pjn_pkg::CHAR_W-1:0]   out_char;
  logic                         last;
  modport source (output valid, out_char, last, input ready);
  modport sink   (input valid, out_char, last, output ready);
endinterface

// ----- hw/rtl/pjn_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pjn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/pjn_front.sv -----
// Front end: takes input beats, classifies the character and queues the item
// for the engine. Depends on pjn_pkg and pjn_if.
module pjn_front (
  input  logic           clk,
  input  logic           rst_n,
  pjn_in_if.sink         in_ch,
  output pjn_pkg::item_t q_item,
  output logic           q_valid,
  input  logic           q_ready
);

  localparam int QD  = pjn_pkg::Q_DEPTH;
  localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCW = $clog2(QD + 1);

  pjn_pkg::item_t   mem_r [QD];
  pjn_pkg::item_t   new_item;
  logic [QAW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             push, pop;

  always_comb begin
    new_item.cmd      = pjn_pkg::cmd_t'(in_ch.command);
    new_item.ch       = in_ch.char_in;
    new_item.is_slash = (in_ch.char_in == pjn_pkg::CH_SLASH);
    new_item.is_dot   = (in_ch.char_in == pjn_pkg::CH_DOT);
    new_item.is_nul   = (in_ch.char_in == pjn_pkg::CH_NUL);
  end

  assign in_ch.ready = (cnt_r < QCW'(QD));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_valid && q_ready;
  assign q_item      = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == QAW'(QD - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == QAW'(QD - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= new_item;
    end
  end

endmodule

// ----- hw/rtl/pjn_back.sv -----
// Engine: builds the segment stack in the character and segment-start RAMs and
// streams the joined path out. Depends on pjn_pkg, pjn_if and pjn_ram.
module pjn_back #(
  parameter int PATH_CHARS   = pjn_pkg::PATH_CHARS_DEF,
  parameter int MAX_SEGMENTS = pjn_pkg::MAX_SEGMENTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pjn_pkg::item_t q_item,
  input  logic           q_valid,
  output logic           q_ready,
  pjn_out_if.source      out_ch
);

  localparam int SC  = 2 * PATH_CHARS;
  localparam int AW  = $clog2(SC);
  localparam int WPW = $clog2(SC + 1);
  localparam int SAW = $clog2(MAX_SEGMENTS);
  localparam int SGW = $clog2(MAX_SEGMENTS + 1);
  localparam int PCW = $clog2(PATH_CHARS);

  typedef struct packed {
    logic [SGW-1:0] cnt;
    logic [WPW-1:0] wp;
    logic [WPW-1:0] open;
    logic [PCW-1:0] pcc;
    logic [1:0]     dot;
    logic           push;
    logic [SAW-1:0] push_idx;
    logic [WPW-1:0] push_val;
    logic           cwe;
    logic [AW-1:0]  cw_addr;
    logic           pop;
  } eng_t;

  function automatic eng_t close_seg(eng_t e_in, logic second);
    eng_t e;
    e = e_in;
    if (e.wp != e.open) begin
      if (second && e.dot == 2'd1) begin
        e.wp = e.open;
      end else if (second && e.dot == 2'd2) begin
        e.wp = e.open;
        if (e.cnt != '0) begin
          e.pop = 1'b1;
        end
      end else if (e.cnt < SGW'(MAX_SEGMENTS)) begin
        e.push     = 1'b1;
        e.push_idx = e.cnt[SAW-1:0];
        e.push_val = e.open;
        e.cnt      = e.cnt + 1'b1;
      end else begin
        e.wp = e.open;
      end
    end
    e.open = e.wp;
    e.dot  = 2'd0;
    return e;
  endfunction

  function automatic eng_t take_char(eng_t e_in, pjn_pkg::item_t it, logic second);
    eng_t e;
    e = e_in;
    if (e.pcc < PCW'(PATH_CHARS - 1)) begin
      if (it.is_nul) begin
        e.pcc = PCW'(PATH_CHARS - 1);
      end else begin
        // a leading slash in the second path drops everything kept so far
        if (second && e.pcc == '0 && it.is_slash) begin
          e.cnt  = '0;
          e.wp   = '0;
          e.open = '0;
          e.dot  = 2'd0;
        end
        e.pcc = e.pcc + 1'b1;
        if (it.is_slash) begin
          e = close_seg(e, second);
        end else begin
          if (e.wp < WPW'(SC)) begin
            e.cwe     = 1'b1;
            e.cw_addr = e.wp[AW-1:0];
            e.wp      = e.wp + 1'b1;
          end
          if (it.is_dot && e.dot < 2'd2) begin
            e.dot = e.dot + 1'b1;
          end else begin
            e.dot = 2'd3;
          end
        end
      end
    end
    return e;
  endfunction

  pjn_pkg::bst_t   st_r, st_nxt;
  pjn_pkg::phase_t ph_r, ph_nxt;
  logic [SGW-1:0]  cnt_r, cnt_nxt, ro_seg_r, ro_seg_nxt;
  logic [WPW-1:0]  wp_r, wp_nxt, open_r, open_nxt;
  logic [WPW-1:0]  ro_ptr_r, ro_ptr_nxt, ro_end_r, ro_end_nxt;
  logic [PCW-1:0]  pcc_r, pcc_nxt;
  logic [1:0]      dot_r, dot_nxt;
  logic            pend_r, pend_nxt;
  logic            out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [7:0]      out_char_r, out_char_nxt;

  logic            cwe, swe;
  logic [AW-1:0]   cwaddr, craddr;
  logic [7:0]      crdata;
  logic [SAW-1:0]  swaddr, sraddr;
  logic [WPW-1:0]  swdata, srdata;
  logic [SGW-1:0]  seg_inc;
  logic [WPW-1:0]  ptr_inc;
  eng_t            e;

  pjn_ram #(.WIDTH(8), .DEPTH(SC)) u_char_ram (
    .clk(clk), .we(cwe), .waddr(cwaddr), .wdata(q_item.ch),
    .raddr(craddr), .rdata(crdata)
  );

  pjn_ram #(.WIDTH(WPW), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
    .clk(clk), .we(swe), .waddr(swaddr), .wdata(swdata),
    .raddr(sraddr), .rdata(srdata)
  );

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_char = out_char_r;
  assign out_ch.last     = out_last_r;
  assign q_ready         = (st_r == pjn_pkg::B_IDLE);
  assign seg_inc         = ro_seg_r + 1'b1;
  assign ptr_inc         = ro_ptr_r + 1'b1;

  always_comb begin
    st_nxt        = st_r;
    ph_nxt        = ph_r;
    cnt_nxt       = cnt_r;
    wp_nxt        = wp_r;
    open_nxt      = open_r;
    pcc_nxt       = pcc_r;
    dot_nxt       = dot_r;
    pend_nxt      = pend_r;
    ro_seg_nxt    = ro_seg_r;
    ro_ptr_nxt    = ro_ptr_r;
    ro_end_nxt    = ro_end_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    cwe           = 1'b0;
    cwaddr        = '0;
    swe           = 1'b0;
    swaddr        = '0;
    swdata        = '0;
    craddr        = ro_ptr_r[AW-1:0];
    sraddr        = seg_inc[SAW-1:0];

    e          = '0;
    e.cnt      = cnt_r;
    e.wp       = wp_r;
    e.open     = open_r;
    e.pcc      = pcc_r;
    e.dot      = dot_r;

    case (st_r)
      pjn_pkg::B_IDLE: begin
        if (q_valid) begin
          case (q_item.cmd)
            pjn_pkg::CMD_CLEAR: begin
              e.cnt = '0; e.wp = '0; e.open = '0; e.pcc = '0; e.dot = 2'd0;
              ro_seg_nxt = '0;
              ro_ptr_nxt = '0;
              ph_nxt     = pjn_pkg::PH_BASE;
            end
            pjn_pkg::CMD_BASE: begin
              if (ph_r == pjn_pkg::PH_IDLE) begin
                e.cnt = '0; e.wp = '0; e.open = '0; e.pcc = '0; e.dot = 2'd0;
                ro_seg_nxt = '0;
                ro_ptr_nxt = '0;
                ph_nxt     = pjn_pkg::PH_BASE;
              end
              if (ph_r == pjn_pkg::PH_IDLE || ph_r == pjn_pkg::PH_BASE) begin
                e = take_char(e, q_item, 1'b0);
              end
            end
            pjn_pkg::CMD_SECOND: begin
              if (ph_r == pjn_pkg::PH_IDLE || ph_r == pjn_pkg::PH_BASE) begin
                e     = close_seg(e, 1'b0);
                e.pcc = '0;
              end
              if (ph_r != pjn_pkg::PH_READ) begin
                ph_nxt = pjn_pkg::PH_SECOND;
                e      = take_char(e, q_item, 1'b1);
              end
            end
            pjn_pkg::CMD_READ: begin
              if (ph_r != pjn_pkg::PH_READ) begin
                e          = close_seg(e, ph_r == pjn_pkg::PH_SECOND);
                ph_nxt     = pjn_pkg::PH_READ;
                ro_seg_nxt = '0;
                ro_ptr_nxt = '0;
              end
              pend_nxt = 1'b1;
              st_nxt   = pjn_pkg::B_RD;
            end
            default: begin
            end
          endcase
          cnt_nxt  = e.cnt;
          wp_nxt   = e.wp;
          open_nxt = e.open;
          pcc_nxt  = e.pcc;
          dot_nxt  = e.dot;
          swe      = e.push;
          swaddr   = e.push_idx;
          swdata   = e.push_val;
          cwe      = e.cwe;
          cwaddr   = e.cw_addr;
          if (e.pop) begin
            // fetch the start of the newest segment, finish the pop next cycle
            sraddr = SAW'(e.cnt - 1'b1);
            st_nxt = pjn_pkg::B_POP;
          end
        end
      end
      pjn_pkg::B_POP: begin
        cnt_nxt  = cnt_r - 1'b1;
        wp_nxt   = srdata;
        open_nxt = srdata;
        dot_nxt  = 2'd0;
        st_nxt   = pend_r ? pjn_pkg::B_RD : pjn_pkg::B_IDLE;
      end
      pjn_pkg::B_RD: begin
        // wait for a free output slot so the RAM data need not be held
        if (!out_valid_r) begin
          pend_nxt = 1'b0;
          if (cnt_r == '0) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = pjn_pkg::CH_SLASH;
            out_last_nxt  = 1'b1;
            ro_seg_nxt    = '0;
            ro_ptr_nxt    = '0;
            st_nxt        = pjn_pkg::B_IDLE;
          end else if (ro_seg_r == '0 || ro_ptr_r >= ro_end_r) begin
            st_nxt = pjn_pkg::B_SLASH;
          end else begin
            st_nxt = pjn_pkg::B_CHAR;
          end
        end
      end
      pjn_pkg::B_SLASH: begin
        // segments sit back to back: this one starts where the last ended
        out_valid_nxt = 1'b1;
        out_char_nxt  = pjn_pkg::CH_SLASH;
        out_last_nxt  = 1'b0;
        ro_ptr_nxt    = (ro_seg_r == '0) ? '0 : ro_end_r;
        ro_end_nxt    = (seg_inc < cnt_r) ? srdata : wp_r;
        ro_seg_nxt    = seg_inc;
        st_nxt        = pjn_pkg::B_IDLE;
      end
      pjn_pkg::B_CHAR: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = crdata;
        if (ro_seg_r == cnt_r && ptr_inc >= ro_end_r) begin
          out_last_nxt = 1'b1;
          ro_seg_nxt   = '0;
          ro_ptr_nxt   = '0;
        end else begin
          out_last_nxt = 1'b0;
          ro_ptr_nxt   = ptr_inc;
        end
        st_nxt = pjn_pkg::B_IDLE;
      end
      default: begin
        st_nxt = pjn_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= pjn_pkg::B_IDLE;
      ph_r        <= pjn_pkg::PH_IDLE;
      cnt_r       <= '0;
      wp_r        <= '0;
      open_r      <= '0;
      pcc_r       <= '0;
      dot_r       <= 2'd0;
      pend_r      <= 1'b0;
      ro_seg_r    <= '0;
      ro_ptr_r    <= '0;
      ro_end_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ph_r        <= ph_nxt;
      cnt_r       <= cnt_nxt;
      wp_r        <= wp_nxt;
      open_r      <= open_nxt;
      pcc_r       <= pcc_nxt;
      dot_r       <= dot_nxt;
      pend_r      <= pend_nxt;
      ro_seg_r    <= ro_seg_nxt;
      ro_ptr_r    <= ro_ptr_nxt;
      ro_end_r    <= ro_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == pjn_pkg::B_SLASH || st_r == pjn_pkg::B_CHAR) |-> !out_valid_r)
    else $error("readout data stage entered with output slot full");
  a_seg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SGW'(MAX_SEGMENTS))
    else $error("segment count beyond stack depth");
  a_ro_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ro_seg_r <= cnt_r)
    else $error("readout segment beyond segment count");
  a_pop_once: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == pjn_pkg::B_POP |=> st_r == pjn_pkg::B_IDLE || st_r == pjn_pkg::B_RD)
    else $error("pop did not complete in one cycle");
`endif

endmodule

// ----- hw/rtl/path_join_normalizer.sv -----
// Top level of the path join normaliser: front end, item queue and engine.
// Depends on pjn_pkg, pjn_if, pjn_front and pjn_back.
//
//  port    | dir | beat                 | payload
//  --------+-----+----------------------+--------------------------------
//  in_ch   | in  | one command          | command[1:0], char_in[7:0]
//  out_ch  | out | one result character | out_char[7:0], last
//
// Path characters and clears are taken in the idle state; a slash that closes a
// ".." in the second path, or a read that first closes one, passes the pop state
// (segment-start RAM read). A read then goes through the read state and the slash
// or character state fed by the registered RAM reads, or just a slash if empty.
// A two-entry queue lets the input take beats while the engine is busy, until full.
// Reset clears all control state; the RAM contents start undefined.
module path_join_normalizer #(
  parameter int PATH_CHARS   = pjn_pkg::PATH_CHARS_DEF,
  parameter int MAX_SEGMENTS = pjn_pkg::MAX_SEGMENTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pjn_in_if.sink    in_ch,
  pjn_out_if.source out_ch
);

  pjn_pkg::item_t q_item;
  logic           q_valid;
  logic           q_ready;

  pjn_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_item(q_item), .q_valid(q_valid), .q_ready(q_ready)
  );

  pjn_back #(
    .PATH_CHARS(PATH_CHARS),
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_item(q_item), .q_valid(q_valid), .q_ready(q_ready),
    .out_ch(out_ch)
  );

endmodule
